// ===== hdl/shpc_pkg.sv =====
package shpc_pkg;

	localparam int POS_WIDTH = 16;
	localparam int OFS_WIDTH = 8;

	localparam logic [OFS_WIDTH-1:0] OFFSET_STEPS_RESET = 8'd12;

	// commands
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_GOTO  = 2'd1;
	localparam logic [1:0] CMD_CALIB = 2'd2;

	// phases
	localparam logic [1:0] PH_CALIB  = 2'd0;
	localparam logic [1:0] PH_IDLE   = 2'd1;
	localparam logic [1:0] PH_MOVING = 2'd2;
	localparam logic [1:0] PH_OFFSET = 2'd3;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] target_position;
		logic        detector_active;
	} in_item_t;

	typedef struct packed {
		logic        step_right;
		logic        step_left;
		logic [15:0] position;
		logic [1:0]  phase;
	} out_item_t;

endpackage

// ===== hdl/shpc_ctrl.sv =====
module shpc_ctrl
	import shpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  in_item_t             item,
	input  logic [OFS_WIDTH-1:0] offset_steps,
	output out_item_t            result
);

	logic [1:0]           phase_q, phase_d;
	logic [POS_WIDTH-1:0] cur_q, cur_d;
	logic [POS_WIDTH-1:0] des_q, des_d;
	logic [OFS_WIDTH-1:0] ofs_cnt_q, ofs_cnt_d;
	logic                 sr, sl;

	always_comb begin
		phase_d   = phase_q;
		cur_d     = cur_q;
		des_d     = des_q;
		ofs_cnt_d = ofs_cnt_q;
		sr        = 1'b0;
		sl        = 1'b0;
		unique case (item.command)
			CMD_TICK: begin
				unique case (phase_q)
					PH_CALIB: begin
						if (!item.detector_active) begin
							sr = 1'b1;
						end else begin
							cur_d   = '0;
							des_d   = '0;
							phase_d = PH_OFFSET;
						end
					end
					PH_IDLE: begin
						if (cur_q != des_q) begin
							phase_d = PH_MOVING;
						end
					end
					PH_MOVING: begin
						if (cur_q < des_q) begin
							sr    = 1'b1;
							cur_d = cur_q + 1'b1;
						end else if (cur_q > des_q) begin
							sl    = 1'b1;
							cur_d = cur_q - 1'b1;
						end else begin
							phase_d = PH_IDLE;
						end
					end
					PH_OFFSET: begin
						if (ofs_cnt_q < offset_steps) begin
							sr        = 1'b1;
							ofs_cnt_d = ofs_cnt_q + 1'b1;
						end else begin
							ofs_cnt_d = '0;
							phase_d   = PH_IDLE;
						end
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
			CMD_GOTO: begin
				des_d   = POS_WIDTH'(item.target_position);
				phase_d = PH_MOVING;
			end
			CMD_CALIB: begin
				phase_d   = PH_CALIB;
				ofs_cnt_d = '0;
			end
			default: begin
				// unused code: nothing changes
				phase_d = phase_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_CALIB;
			cur_q     <= '0;
			des_q     <= '0;
			ofs_cnt_q <= '0;
		end else if (en) begin
			phase_q   <= phase_d;
			cur_q     <= cur_d;
			des_q     <= des_d;
			ofs_cnt_q <= ofs_cnt_d;
		end
	end

	assign result.step_right = sr;
	assign result.step_left  = sl;
	assign result.position   = 16'(cur_d);
	assign result.phase      = phase_d;

`ifndef SYNTHESIS
	a_one_dir: assert property (@(posedge clk) disable iff (!arst_n)
		!(sr && sl))
		else $error("step right and left at once");

	a_left_dec: assert property (@(posedge clk) disable iff (!arst_n)
		en && sl |=> cur_q == $past(cur_q) - 1'b1)
		else $error("left step did not decrement position");

	a_calib_clr: assert property (@(posedge clk) disable iff (!arst_n)
		en && item.command == CMD_CALIB |=> ofs_cnt_q == '0 && phase_q == PH_CALIB)
		else $error("calibrate did not restart homing");

	a_goto_nostep: assert property (@(posedge clk) disable iff (!arst_n)
		en && item.command == CMD_GOTO |-> !sr && !sl)
		else $error("goto issued a step");
`endif

endmodule

// ===== hdl/stepper_homing_position_controller_top.sv =====
// Stepper position controller with homing. Each input item is a command: tick,
// goto (load target) or calibrate (restart homing). On ticks the block steps right
// until the home detector is seen, zeroes position, steps right offset_steps more
// times, then moves one step per tick toward the target. Every item gives exactly
// one result item carrying the step pulses, the position and the phase after it.
// An item is held in the input register and its result is written to the output
// register when the output can take it, so a new item is taken every cycle as long
// as the output is drained. offset_steps resets to 12 and should only be written
// while no items are in flight.
module stepper_homing_position_controller_top
	import shpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [OFS_WIDTH-1:0] cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_item
);

	logic [OFS_WIDTH-1:0] offset_steps_q;
	logic                 valid_s1;
	in_item_t             item_s1;
	logic                 out_valid_q;
	out_item_t            out_item_q;
	out_item_t            result;
	logic                 adv_out;
	logic                 en;

	assign adv_out  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv_out;
	assign en       = valid_s1 && adv_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_steps_q <= OFFSET_STEPS_RESET;
		end else if (cfg_wr_en) begin
			offset_steps_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!valid_s1 || adv_out) begin
				valid_s1 <= in_valid;
			end
			if (adv_out) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
		if (en) begin
			out_item_q <= result;
		end
	end

	shpc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.item         (item_s1),
		.offset_steps (offset_steps_q),
		.result       (result)
	);

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`ifndef SYNTHESIS
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with room in the pipe");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q)
		else $error("stalled result dropped");

	a_pass_on: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> out_valid_q)
		else $error("processed item produced no result");
`endif

endmodule

// ===== dv/shpc_motion_checker.sv =====
module shpc_motion_checker
	import shpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [OFS_WIDTH-1:0] cfg_wr_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  in_item_t             in_item,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  out_item_t            out_item,
	output int                   mismatches,
	output int                   outstanding
);

	// shadow of the controller state
	logic [1:0]           m_phase;
	logic [POS_WIDTH-1:0] m_pos;
	logic [POS_WIDTH-1:0] m_target;
	logic [OFS_WIDTH-1:0] m_ofs_count;
	logic [OFS_WIDTH-1:0] m_ofs_steps;

	out_item_t motion_expected[$];
	int        fail_cnt;

	function automatic out_item_t step_motor_model(in_item_t it);
		out_item_t r;
		r = '0;
		case (it.command)
			CMD_TICK: begin
				case (m_phase)
					PH_CALIB: begin
						if (!it.detector_active) begin
							r.step_right = 1'b1;
						end else begin
							m_pos    = '0;
							m_target = '0;
							m_phase  = PH_OFFSET;
						end
					end
					PH_IDLE: begin
						if (m_pos != m_target) m_phase = PH_MOVING;
					end
					PH_MOVING: begin
						if (m_pos < m_target) begin
							r.step_right = 1'b1;
							m_pos = m_pos + 1'b1;
						end else if (m_pos > m_target) begin
							r.step_left = 1'b1;
							m_pos = m_pos - 1'b1;
						end else begin
							m_phase = PH_IDLE;
						end
					end
					default: begin
						// offset: right steps do not move the position
						if (m_ofs_count < m_ofs_steps) begin
							r.step_right = 1'b1;
							m_ofs_count = m_ofs_count + 1'b1;
						end else begin
							m_ofs_count = '0;
							m_phase     = PH_IDLE;
						end
					end
				endcase
			end
			CMD_GOTO: begin
				m_target = it.target_position[POS_WIDTH-1:0];
				m_phase  = PH_MOVING;
			end
			CMD_CALIB: begin
				m_phase     = PH_CALIB;
				m_ofs_count = '0;
			end
			default: ;
		endcase
		r.position = 16'(m_pos);
		r.phase    = m_phase;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch_proc
		out_item_t want;
		if (!arst_n) begin
			m_phase     = PH_CALIB;
			m_pos       = '0;
			m_target    = '0;
			m_ofs_count = '0;
			m_ofs_steps = OFFSET_STEPS_RESET;
			motion_expected.delete();
			fail_cnt = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_wr_en) m_ofs_steps = cfg_wr_data;
			if (out_valid && !out_stall) begin
				if (motion_expected.size() == 0) begin
					fail_cnt++;
					$display("%0t: unexpected result item sr=%0b sl=%0b pos=%0d phase=%0d",
						$time, out_item.step_right, out_item.step_left,
						out_item.position, out_item.phase);
				end else begin
					want = motion_expected.pop_front();
					if (out_item !== want) begin
						fail_cnt++;
						// fields: step_right step_left position phase
						$display("%0t: expected %0b %0b %0d %0d, actual %0b %0b %0d %0d",
							$time, want.step_right, want.step_left, want.position,
							want.phase, out_item.step_right, out_item.step_left,
							out_item.position, out_item.phase);
					end
				end
			end
			if (in_valid && !in_stall) motion_expected.push_back(step_motor_model(in_item));
			mismatches  <= fail_cnt;
			outstanding <= motion_expected.size();
		end
	end

endmodule

// ===== dv/tb_stepper_homing_position_controller_top.sv =====
module tb_stepper_homing_position_controller_top;
	import shpc_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int IDLE_LIMIT  = 1000;
	localparam int HOLD_CYCLES = 120;
	localparam int LATENCY     = 2;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [OFS_WIDTH-1:0] cfg_wr_data;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_item;
	logic                 out_valid;
	logic                 out_stall;
	out_item_t            out_item;

	int mismatches;
	int outstanding;
	bit hold_req;
	int idle_cycles;
	int aim;

	stepper_homing_position_controller_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

	shpc_motion_checker u_motion_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic in_item_t make_item(logic [1:0] cmd, logic [15:0] tgt, logic det);
		in_item_t it;
		it.command         = cmd;
		it.target_position = tgt;
		it.detector_active = det;
		return it;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic send_item(in_item_t it, int gap);
		in_item  <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_all();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_offset(logic [OFS_WIDTH-1:0] v);
		cfg_wr_data <= v;
		cfg_wr_en   <= 1'b1;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// calibrate, then a long run of ticks so a large offset can finish
	task automatic homing_run(int n);
		send_item(make_item(CMD_CALIB, 16'($urandom), 1'($urandom)), pick_gap());
		aim = 0;
		for (int k = 0; k < n; k++)
			send_item(make_item(CMD_TICK, 16'($urandom), ($urandom_range(7) == 0)), pick_gap());
	endtask

	task automatic random_phase(int n, bit stress);
		in_item_t it;
		int       r;
		int       gap;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 68) begin
				it = make_item(CMD_TICK, 16'($urandom), ($urandom_range(7) == 0));
			end else if (r < 86) begin
				// near the last target so moves settle and go idle
				aim = aim + int'($urandom_range(24)) - 12;
				if (aim < 0) aim = 0;
				if (aim > 65535) aim = 65535;
				it = make_item(CMD_GOTO, 16'(aim), 1'($urandom));
			end else if (r < 90) begin
				aim = int'($urandom_range(65535));
				it = make_item(CMD_GOTO, 16'(aim), 1'($urandom));
			end else if (r < 95) begin
				aim = 0;
				it = make_item(CMD_CALIB, 16'($urandom), 1'($urandom));
			end else if (r < 97) begin
				aim = $urandom_range(1) ? 65535 : 0;
				it = make_item(CMD_GOTO, 16'(aim), 1'($urandom));
			end else begin
				it = make_item(CMD_UNUSED, 16'($urandom), 1'($urandom));
			end
			gap = pick_gap();
			if (stress) begin
				if (k == 40) hold_req = 1'b1;
				if ((k >= 40 && k < 80) || (k >= 180 && k < 240)) gap = 0;
				if (k == 120) drain_all();
			end
			send_item(it, gap);
		end
	endtask

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin : drain_ctrl
		int len;
		out_stall <= 1'b0;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				case ($urandom_range(9))
					0, 1, 2, 3: begin
						out_stall <= 1'b0;
						len = $urandom_range(1, 30);
					end
					4, 5, 6, 7: begin
						out_stall <= 1'b1;
						len = $urandom_range(1, 3);
					end
					8: begin
						out_stall <= 1'b1;
						len = $urandom_range(4, 12);
					end
					default: begin
						out_stall <= 1'b1;
						len = $urandom_range(15, 40);
					end
				endcase
				repeat (len) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin : stimulus
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		in_valid    <= 1'b0;
		in_item     <= '0;
		hold_req     = 1'b0;
		aim          = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// homing, goto during offset, moves both ways, unused code, recalibrate
		send_item(make_item(CMD_TICK,   16'hFFFF, 1'b0), 0);
		send_item(make_item(CMD_TICK,   16'h0000, 1'b0), 0);
		send_item(make_item(CMD_TICK,   16'hA5A5, 1'b1), 0);
		send_item(make_item(CMD_TICK,   16'h5A5A, 1'b1), 0);
		send_item(make_item(CMD_TICK,   16'h0000, 1'b0), 0);
		send_item(make_item(CMD_GOTO,   16'hFFFF, 1'b0), 0);
		send_item(make_item(CMD_TICK,   16'h0000, 1'b1), 0);
		send_item(make_item(CMD_TICK,   16'h0000, 1'b0), 0);
		send_item(make_item(CMD_UNUSED, 16'hFFFF, 1'b1), 0);
		send_item(make_item(CMD_GOTO,   16'h0000, 1'b1), 0);
		send_item(make_item(CMD_TICK,   16'hFFFF, 1'b0), 0);
		send_item(make_item(CMD_TICK,   16'hFFFF, 1'b0), 0);
		send_item(make_item(CMD_TICK,   16'h0000, 1'b0), 0);
		send_item(make_item(CMD_TICK,   16'h0000, 1'b1), 0);
		send_item(make_item(CMD_GOTO,   16'h0000, 1'b0), 0);
		send_item(make_item(CMD_TICK,   16'h0000, 1'b0), 0);
		send_item(make_item(CMD_CALIB,  16'hFFFF, 1'b1), 0);
		send_item(make_item(CMD_TICK,   16'h0000, 1'b1), 0);
		send_item(make_item(CMD_TICK,   16'h0000, 1'b0), 0);
		send_item(make_item(CMD_CALIB,  16'h0000, 1'b0), 0);
		aim = 0;

		// reset offset first, then zero, max, random and a small one
		random_phase(150, 1'b0);
		drain_all();
		write_offset('0);
		random_phase(200, 1'b0);
		drain_all();
		write_offset('1);
		homing_run(280);
		random_phase(100, 1'b0);
		drain_all();
		write_offset(OFS_WIDTH'($urandom));
		random_phase(250, 1'b1);
		drain_all();
		write_offset(OFS_WIDTH'(1));
		random_phase(150, 1'b0);

		drain_all();
		if (mismatches == 0 && outstanding == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
